/* design/rmfw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmfw_pkg
// Shared types and constants for the recursive mutex with a FIFO wait queue.
// ----------------------------------------------------------------------------
package rmfw_pkg;

    // Thread identifiers and the waiting marks they index
    localparam int TidW       = 4;
    localparam int NumTids    = 1 << TidW;

    // Wait queue sizing
    localparam int MaxThreads = 16;
    localparam int PtrW       = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
    localparam int CntW       = $clog2(MaxThreads + 1);

    // Nesting count
    localparam int NestW      = 8;
    localparam int MaxNest    = 255;
    localparam int NestCapInt = (MaxNest < 255) ? MaxNest : 255;
    localparam logic [NestW-1:0] NestCap = NestW'(NestCapInt);

    // Request codes
    typedef enum logic
    {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [3:0]
    {
        ST_GRANTED    = 4'd0,
        ST_NESTED     = 4'd1,
        ST_QUEUED     = 4'd2,
        ST_NEST_REL   = 4'd3,
        ST_FREED      = 4'd4,
        ST_HANDED     = 4'd5,
        ST_NOT_HOLDER = 4'd6,
        ST_WAITING    = 4'd7,
        ST_OVERFLOW   = 4'd8
    } status_t;

    // Queue state seen by the lock controller
    typedef struct packed
    {
        logic               full;
        logic               empty;
        logic [TidW-1:0]    head_tid;
        logic [NumTids-1:0] marks;
    } queue_stat_t;

    // Queue commands from the lock controller
    typedef struct packed
    {
        logic            push;
        logic            pop;
        logic [TidW-1:0] push_tid;
    } queue_cmd_t;

    // One result beat
    typedef struct packed
    {
        status_t          status;
        logic             wake_valid;
        logic [TidW-1:0]  wake_thread;
        logic [NestW-1:0] depth_after;
    } result_t;

endpackage
`default_nettype wire

/* design/rmfw_wait_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmfw_wait_queue
// FIFO of waiting thread identifiers plus one waiting mark per thread.
// ----------------------------------------------------------------------------
module rmfw_wait_queue
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rmfw_pkg::queue_cmd_t cmd,
    output rmfw_pkg::queue_stat_t    stat
);

    logic [rmfw_pkg::TidW-1:0]    fifo_mem [rmfw_pkg::MaxThreads];
    logic [rmfw_pkg::PtrW-1:0]    head_reg;
    logic [rmfw_pkg::PtrW-1:0]    head_next;
    logic [rmfw_pkg::PtrW-1:0]    tail_reg;
    logic [rmfw_pkg::PtrW-1:0]    tail_next;
    logic [rmfw_pkg::CntW-1:0]    count_reg;
    logic [rmfw_pkg::CntW-1:0]    count_next;
    logic [rmfw_pkg::NumTids-1:0] marks_reg;
    logic [rmfw_pkg::NumTids-1:0] marks_next;
    logic [rmfw_pkg::TidW-1:0]    head_tid;

    localparam logic [rmfw_pkg::PtrW-1:0] LastSlot = rmfw_pkg::PtrW'(rmfw_pkg::MaxThreads - 1);
    localparam logic [rmfw_pkg::CntW-1:0] FullCnt  = rmfw_pkg::CntW'(rmfw_pkg::MaxThreads);

    assign head_tid = fifo_mem[head_reg];

    // Advance pointers, count and marks
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        marks_next = marks_reg;
        if (cmd.push)
        begin
            tail_next  = (tail_reg == LastSlot) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
            marks_next[cmd.push_tid] = 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next  = (head_reg == LastSlot) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
            marks_next[head_tid] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            marks_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            marks_reg <= marks_next;
        end
    end

    // Store a pushed identifier at the tail
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            fifo_mem[tail_reg] <= cmd.push_tid;
        end
    end

    assign stat.full     = (count_reg >= FullCnt);
    assign stat.empty    = (count_reg == '0);
    assign stat.head_tid = head_tid;
    assign stat.marks    = marks_reg;

endmodule
`default_nettype wire

/* design/rmfw_lock_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmfw_lock_ctrl
// Lock owner and nesting state; decides the outcome of one request.
// ----------------------------------------------------------------------------
module rmfw_lock_ctrl
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      fire,
    input  wire rmfw_pkg::op_t             op,
    input  wire logic [rmfw_pkg::TidW-1:0] tid,
    input  wire rmfw_pkg::queue_stat_t     qstat,
    output rmfw_pkg::queue_cmd_t           qcmd,
    output rmfw_pkg::result_t              result
);

    logic                       taken_reg;
    logic                       taken_next;
    logic [rmfw_pkg::TidW-1:0]  owner_reg;
    logic [rmfw_pkg::TidW-1:0]  owner_next;
    logic [rmfw_pkg::NestW-1:0] nest_reg;
    logic [rmfw_pkg::NestW-1:0] nest_next;
    logic                       is_holder;
    logic                       push;
    logic                       pop;

    assign is_holder = taken_reg && (owner_reg == tid);

    // Decide the outcome and the next lock state
    always_comb
    begin
        taken_next         = taken_reg;
        owner_next         = owner_reg;
        nest_next          = nest_reg;
        push               = 1'b0;
        pop                = 1'b0;
        result.wake_valid  = 1'b0;
        result.wake_thread = '0;
        result.status      = rmfw_pkg::ST_NOT_HOLDER;
        case (op)
            rmfw_pkg::OP_ACQUIRE:
            begin
                if (is_holder)
                begin
                    if (nest_reg >= rmfw_pkg::NestCap)
                    begin
                        result.status = rmfw_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        nest_next     = nest_reg + 1'b1;
                        result.status = rmfw_pkg::ST_NESTED;
                    end
                end
                else if (qstat.marks[tid] || (taken_reg && qstat.full))
                begin
                    result.status = rmfw_pkg::ST_WAITING;
                end
                else if (!taken_reg)
                begin
                    taken_next    = 1'b1;
                    owner_next    = tid;
                    nest_next     = rmfw_pkg::NestW'(1);
                    result.status = rmfw_pkg::ST_GRANTED;
                end
                else
                begin
                    push          = 1'b1;
                    result.status = rmfw_pkg::ST_QUEUED;
                end
            end
            rmfw_pkg::OP_RELEASE:
            begin
                if (!is_holder)
                begin
                    result.status = rmfw_pkg::ST_NOT_HOLDER;
                end
                else if (nest_reg > rmfw_pkg::NestW'(1))
                begin
                    nest_next     = nest_reg - 1'b1;
                    result.status = rmfw_pkg::ST_NEST_REL;
                end
                else if (!qstat.empty)
                begin
                    // Hand the lock straight to the oldest waiter
                    pop                = 1'b1;
                    owner_next         = qstat.head_tid;
                    nest_next          = rmfw_pkg::NestW'(1);
                    result.wake_valid  = 1'b1;
                    result.wake_thread = qstat.head_tid;
                    result.status      = rmfw_pkg::ST_HANDED;
                end
                else
                begin
                    taken_next    = 1'b0;
                    owner_next    = '0;
                    nest_next     = '0;
                    result.status = rmfw_pkg::ST_FREED;
                end
            end
            default:
            begin
                result.status = rmfw_pkg::ST_NOT_HOLDER;
            end
        endcase
        result.depth_after = nest_next;
    end

    // Gate queue commands with the processing strobe
    assign qcmd.push     = fire && push;
    assign qcmd.pop      = fire && pop;
    assign qcmd.push_tid = tid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
            owner_reg <= '0;
            nest_reg  <= '0;
        end
        else if (fire)
        begin
            taken_reg <= taken_next;
            owner_reg <= owner_next;
            nest_reg  <= nest_next;
        end
    end

endmodule
`default_nettype wire

/* design/recursive_mutex_fifo_waiters.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_waiters
// Recursive mutex with a FIFO of waiting threads and direct handoff.
// ----------------------------------------------------------------------------
// Each request beat names a thread and asks to acquire or release the lock;
// exactly one result beat comes back per request, in order. A request is
// registered on entry, resolved by the lock controller and the wait queue
// while it waits in the input register, and its result is loaded into an
// output register on the edge that lets it advance, so one request is taken
// every cycle while the result side keeps up. The owner, nesting count and
// queue pointers are updated on that same edge. The waiting queue needs no
// clearing after reset.
module recursive_mutex_fifo_waiters
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic                       operation,
    input  wire logic [rmfw_pkg::TidW-1:0]  thread_id,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic [3:0]                      status,
    output logic                            wake_valid,
    output logic [rmfw_pkg::TidW-1:0]       wake_thread,
    output logic [rmfw_pkg::NestW-1:0]      depth_after
);

    logic                      in_valid_reg;
    logic                      in_op_reg;
    logic [rmfw_pkg::TidW-1:0] in_tid_reg;
    logic                      advance;
    logic                      accept;
    logic                      rsp_valid_reg;
    rmfw_pkg::result_t         result;
    rmfw_pkg::result_t         result_reg;
    rmfw_pkg::queue_cmd_t      qcmd;
    rmfw_pkg::queue_stat_t     qstat;

    // Resolve the held request when the result register is free
    assign advance   = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg  <= operation;
            in_tid_reg <= thread_id;
        end
    end

    rmfw_lock_ctrl u_lock_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .op     (rmfw_pkg::op_t'(in_op_reg)),
        .tid    (in_tid_reg),
        .qstat  (qstat),
        .qcmd   (qcmd),
        .result (result)
    );

    rmfw_wait_queue u_wait_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (qcmd),
        .stat  (qstat)
    );

    // Result register: load on advance, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = result_reg.status;
    assign wake_valid  = result_reg.wake_valid;
    assign wake_thread = result_reg.wake_thread;
    assign depth_after = result_reg.depth_after;

endmodule
`default_nettype wire

/* tb/recursive_mutex_fifo_waiters_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_waiters_test
// Self-checking bench for the recursive mutex with a FIFO wait queue.
// ----------------------------------------------------------------------------
// Walks a table of directed requests: free-lock release, grant, nesting up to
// the count ceiling and the overflow reject, queueing, double queueing,
// foreign release and handoff along a wait queue holding every other thread.
// Then it sends random lock traffic, half of it acquire/release by the holder
// while the lock is held, under three idle profiles. A request-level lock
// predictor supplies the expected result beats the table does not type in,
// and the result channel is compared field by field in order.
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_waiters_test;

    import rmfw_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 140;
    localparam int DRAIN_CYCLES = 8;

    // One directed row: a request, optionally repeated, with or without a
    // result typed in by hand
    typedef struct {
        op_t        op;
        logic [3:0] tid;
        bit         by_owner;
        bit         sweep;
        int         reps;
        bit         typed;
        result_t    want;
    } stim_row_t;

    localparam result_t FROM_MODEL = '0;

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             req_valid   = 1'b0;
    logic             req_stall;
    logic             operation   = OP_ACQUIRE;
    logic [TidW-1:0]  thread_id   = '0;
    logic             rsp_valid;
    logic             rsp_stall   = 1'b0;
    logic [3:0]       status;
    logic             wake_valid;
    logic [TidW-1:0]  wake_thread;
    logic [NestW-1:0] depth_after;

    // Lock predictor state
    logic             lock_held;
    logic [TidW-1:0]  lock_owner;
    logic [NestW-1:0] lock_depth;
    logic [TidW-1:0]  waiter_ring [MaxThreads];
    int               ring_head;
    int               ring_tail;
    int               waiter_count;
    logic             queued_mark [NumTids];

    result_t          pending_results [$];
    int               src_idle_pct;
    int               sink_stall_pct;
    int               fail_count;
    int               requests_sent;
    int               results_checked;
    int               cycle_count;
    int               status_seen [16];

    stim_row_t directed_rows [23] = '{
        '{OP_RELEASE, 4'd0,  0, 0, 1,   1, '{ST_NOT_HOLDER, 1'b0, 4'd0,  8'd0}},
        '{OP_ACQUIRE, 4'd0,  0, 0, 1,   1, '{ST_GRANTED,    1'b0, 4'd0,  8'd1}},
        '{OP_ACQUIRE, 4'd0,  0, 0, 1,   1, '{ST_NESTED,     1'b0, 4'd0,  8'd2}},
        '{OP_ACQUIRE, 4'd15, 0, 0, 1,   1, '{ST_QUEUED,     1'b0, 4'd0,  8'd2}},
        '{OP_ACQUIRE, 4'd15, 0, 0, 1,   1, '{ST_WAITING,    1'b0, 4'd0,  8'd2}},
        '{OP_RELEASE, 4'd15, 0, 0, 1,   1, '{ST_NOT_HOLDER, 1'b0, 4'd0,  8'd2}},
        '{OP_ACQUIRE, 4'd5,  0, 0, 1,   1, '{ST_QUEUED,     1'b0, 4'd0,  8'd2}},
        '{OP_RELEASE, 4'd0,  0, 0, 1,   1, '{ST_NEST_REL,   1'b0, 4'd0,  8'd1}},
        '{OP_RELEASE, 4'd0,  0, 0, 1,   1, '{ST_HANDED,     1'b1, 4'd15, 8'd1}},
        '{OP_ACQUIRE, 4'd15, 0, 0, 1,   1, '{ST_NESTED,     1'b0, 4'd0,  8'd2}},
        '{OP_RELEASE, 4'd15, 0, 0, 2,   0, FROM_MODEL},
        '{OP_RELEASE, 4'd5,  0, 0, 1,   1, '{ST_FREED,      1'b0, 4'd0,  8'd0}},
        '{OP_ACQUIRE, 4'd9,  0, 0, 1,   1, '{ST_GRANTED,    1'b0, 4'd0,  8'd1}},
        '{OP_ACQUIRE, 4'd9,  0, 0, 254, 0, FROM_MODEL},
        '{OP_ACQUIRE, 4'd9,  0, 0, 1,   1, '{ST_OVERFLOW,   1'b0, 4'd0,  8'd255}},
        '{OP_ACQUIRE, 4'd6,  0, 0, 1,   1, '{ST_QUEUED,     1'b0, 4'd0,  8'd255}},
        '{OP_RELEASE, 4'd9,  0, 0, 254, 0, FROM_MODEL},
        '{OP_RELEASE, 4'd9,  0, 0, 1,   1, '{ST_HANDED,     1'b1, 4'd6,  8'd1}},
        '{OP_RELEASE, 4'd6,  0, 0, 1,   1, '{ST_FREED,      1'b0, 4'd0,  8'd0}},
        '{OP_ACQUIRE, 4'd3,  0, 0, 1,   1, '{ST_GRANTED,    1'b0, 4'd0,  8'd1}},
        '{OP_ACQUIRE, 4'd0,  0, 1, 16,  0, FROM_MODEL},
        '{OP_RELEASE, 4'd0,  1, 0, 17,  0, FROM_MODEL},
        '{OP_ACQUIRE, 4'd10, 0, 0, 1,   1, '{ST_GRANTED,    1'b0, 4'd0,  8'd1}}
    };

    recursive_mutex_fifo_waiters dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .thread_id   (thread_id),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .wake_valid  (wake_valid),
        .wake_thread (wake_thread),
        .depth_after (depth_after)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Advance the predicted lock state by one request and return its result
    function automatic result_t mutex_predict(input op_t op, input logic [TidW-1:0] tid);
        result_t          r;
        logic             holder;
        logic [TidW-1:0]  woken;
        holder        = lock_held && (lock_owner == tid);
        r.wake_valid  = 1'b0;
        r.wake_thread = '0;
        if (op == OP_ACQUIRE)
        begin
            if (holder)
            begin
                if (lock_depth >= NestCap)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    lock_depth = lock_depth + 1'b1;
                    r.status   = ST_NESTED;
                end
            end
            else if (queued_mark[tid])
            begin
                r.status = ST_WAITING;
            end
            else if (!lock_held)
            begin
                lock_held  = 1'b1;
                lock_owner = tid;
                lock_depth = 8'd1;
                r.status   = ST_GRANTED;
            end
            else if (waiter_count >= MaxThreads)
            begin
                r.status = ST_WAITING;
            end
            else
            begin
                waiter_ring[ring_tail] = tid;
                ring_tail              = (ring_tail + 1) % MaxThreads;
                waiter_count++;
                queued_mark[tid]       = 1'b1;
                r.status               = ST_QUEUED;
            end
        end
        else
        begin
            if (!holder)
            begin
                r.status = ST_NOT_HOLDER;
            end
            else if (lock_depth > 8'd1)
            begin
                lock_depth = lock_depth - 1'b1;
                r.status   = ST_NEST_REL;
            end
            else if (waiter_count > 0)
            begin
                woken              = waiter_ring[ring_head];
                ring_head          = (ring_head + 1) % MaxThreads;
                waiter_count--;
                queued_mark[woken] = 1'b0;
                lock_owner         = woken;
                lock_depth         = 8'd1;
                r.wake_valid       = 1'b1;
                r.wake_thread      = woken;
                r.status           = ST_HANDED;
            end
            else
            begin
                lock_held  = 1'b0;
                lock_owner = '0;
                lock_depth = '0;
                r.status   = ST_FREED;
            end
        end
        r.depth_after = lock_depth;
        return r;
    endfunction

    // Queue the expected result, then hold the request beat until it is taken
    task automatic issue_request(input op_t op, input logic [TidW-1:0] tid,
                                 input bit typed, input result_t typed_want);
        result_t model_want;
        model_want = mutex_predict(op, tid);
        pending_results.push_back(typed ? typed_want : model_want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        thread_id <= tid;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Check each result beat against the oldest expectation; randomize stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result beat, status %0d", $time, status);
                fail_count++;
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                check_field("status",      want.status,      status);
                check_field("wake_valid",  want.wake_valid,  wake_valid);
                check_field("wake_thread", want.wake_thread, wake_thread);
                check_field("depth_after", want.depth_after, depth_after);
                results_checked++;
                status_seen[status]++;
            end
        end
        rsp_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [TidW-1:0] pick_tid;
        int              pick;
        op_t             pick_op;

        lock_held      = 1'b0;
        lock_owner     = '0;
        lock_depth     = '0;
        ring_head      = 0;
        ring_tail      = 0;
        waiter_count   = 0;
        fail_count     = 0;
        requests_sent  = 0;
        cycle_count    = 0;
        foreach (queued_mark[i])
            queued_mark[i] = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        results_checked = 0;
        src_idle_pct    = 12;
        sink_stall_pct  = 46;

        // Hold reset, then release it on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            for (int n = 0; n < directed_rows[i].reps; n++)
            begin
                if (directed_rows[i].by_owner)
                    pick_tid = lock_owner;
                else
                    pick_tid = directed_rows[i].tid +
                               TidW'(directed_rows[i].sweep ? n : 0);
                issue_request(directed_rows[i].op, pick_tid,
                              directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random lock traffic, biased toward holder releases and nesting
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 3)
            begin
                src_idle_pct   = 46;
                sink_stall_pct = 12;
            end
            else if (k == 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            pick     = $urandom_range(99);
            pick_tid = TidW'($urandom_range(NumTids - 1));
            if (pick < 40)
            begin
                pick_op = OP_ACQUIRE;
            end
            else if (pick < 75)
            begin
                pick_op = OP_RELEASE;
                if (lock_held)
                    pick_tid = lock_owner;
            end
            else if (pick < 85)
            begin
                pick_op = OP_RELEASE;
            end
            else
            begin
                pick_op = OP_ACQUIRE;
                if (lock_held)
                    pick_tid = lock_owner;
            end
            issue_request(pick_op, pick_tid, 1'b0, FROM_MODEL);
        end
        req_valid <= 1'b0;

        // Drain outstanding results, then let late beats show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d lock requests and checked %0d results under three idle profiles",
                 requests_sent, results_checked);
        $display("Handoffs %0d, nest overflows %0d, double-queue rejects %0d, foreign releases %0d",
                 status_seen[ST_HANDED], status_seen[ST_OVERFLOW],
                 status_seen[ST_WAITING], status_seen[ST_NOT_HOLDER]);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
